[hdl/fnsr_pkg.sv]
// Package for the fp32 Newton square root block.
// Holds fp32 constants, the sequencer state type and the unit op codes.
package fnsr_pkg;
	localparam logic [31:0] FP_HIDDEN = 32'h0080_0000;
	localparam logic [31:0] FP_FRAC   = 32'h007F_FFFF;
	localparam logic [31:0] FP_SIGN   = 32'h8000_0000;
	localparam logic [31:0] FP_INF    = 32'h7F80_0000;
	localparam logic [31:0] FP_TWO    = 32'h4000_0000;
	localparam int FP_BIAS  = 127;
	localparam int QUO_BITS = 25;
	localparam logic [3:0] ITER_RESET = 4'd5;

	typedef enum logic [1:0] {
		OP_DIV,
		OP_ADD
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DIVQ,
		ST_ADD,
		ST_DIVH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;
endpackage

[hdl/fnsr_conv.sv]
// Integer to fp32 conversion with truncation, and initial guess.
// Depends on fnsr_pkg. One leading-zero search per register stage.
module fnsr_conv import fnsr_pkg::*; (
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] radicand,
	output logic [31:0] value_q,
	output logic [31:0] guess_q
);
	logic [4:0]  msb;
	logic [31:0] shifted;
	logic [4:0]  half;
	logic [4:0]  msb_g;
	logic [31:0] xg;

	function automatic logic [31:0] to_fp(input logic [31:0] v, input logic [4:0] e);
		logic [31:0] m;
		begin
			if (e <= 5'd23) m = v << (5'd23 - e);
			else m = v >> (e - 5'd23);
			to_fp = ({24'd0, 3'd0, e} + 32'(FP_BIAS)) << 23 | (m & FP_FRAC);
		end
	endfunction

	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++)
			if (radicand[i]) msb = 5'(i);
		half = 5'((6'(msb) + 6'd1) >> 1);
		shifted = radicand >> half;
		msb_g = msb - half;
		xg = shifted;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= (radicand == '0) ? '0 : to_fp(radicand, msb);
			guess_q <= (xg == '0) ? FP_TWO : to_fp(xg, msb_g);
		end
	end
endmodule

[hdl/fnsr_unit.sv]
// Shared fp32 arithmetic unit: restoring divide, one quotient bit a cycle,
// and add with truncating alignment. Depends on fnsr_pkg.
module fnsr_unit import fnsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  unit_ctl_t   ctl,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output unit_sts_t   sts,
	output logic [31:0] res_q
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [25:0] rem_q;
	logic [23:0] den_q;
	logic [24:0] quo_q;
	logic signed [10:0] exp_q;
	logic        sgn_q;
	logic        done_q;
	logic [25:0] diffr;
	logic [23:0] mp, mq;
	logic signed [10:0] e0;
	logic [31:0] add_res;
	logic [24:0] rq;
	logic        up;
	logic signed [10:0] ef;
	logic [31:0] div_res;

	always_comb begin
		mp = {1'b1, a[22:0]};
		mq = {1'b1, b[22:0]};
		e0 = 11'(a[30:23]) - 11'(b[30:23]) + 11'(FP_BIAS);
		diffr = rem_q - {2'b0, den_q};
		up = quo_q[0] && (rem_q != '0 || quo_q[1]);
		rq = {1'b0, quo_q[24:1]} + {24'd0, up};
		ef = rq[24] ? exp_q + 11'sd1 : exp_q;
		if (rq[24]) rq = rq >> 1;
		if (ef <= 0) div_res = {sgn_q, 31'd0};
		else if (ef >= 255) div_res = {sgn_q, 31'd0} | FP_INF;
		else div_res = {sgn_q, ef[7:0], rq[22:0]};
	end

	// Adder, combinational; the normalize step searches for the leading one.
	always_comb begin
		logic [30:0] aa, ab;
		logic        sa, sb;
		logic [7:0]  ea, eb, df;
		logic [24:0] ma, mb, m;
		logic signed [10:0] e;
		int sh;
		aa = a[30:0]; ab = b[30:0]; sa = a[31]; sb = b[31];
		if (aa < ab) begin
			aa = b[30:0]; ab = a[30:0]; sa = b[31]; sb = a[31];
		end
		ea = aa[30:23]; eb = ab[30:23];
		ma = {1'b0, ea != 0, aa[22:0]};
		mb = {1'b0, eb != 0, ab[22:0]};
		df = ea - eb;
		mb = (df < 8'd25) ? mb >> df : '0;
		m = (sa != sb) ? ma - mb : ma + mb;
		e = 11'(ea);
		sh = 0;
		if (m[24]) begin
			m = m >> 1; e = e + 11'sd1;
		end else begin
			for (int i = 23; i >= 0; i--)
				if (m[i] && sh == 0) sh = 24 - i;
			m = m << (sh - 1);
			e = e - 11'(sh - 1);
		end
		if (a[30:0] == '0) add_res = b;
		else if (b[30:0] == '0) add_res = a;
		else if (m == '0) add_res = '0;
		else if (e <= 0) add_res = '0;
		else if (e >= 255) add_res = {sa, 31'd0} | FP_INF;
		else add_res = {sa, e[7:0], m[22:0]};
	end

	assign sts.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				unique case (ctl.op)
					OP_ADD: begin
						res_q  <= add_res;
						done_q <= 1'b1;
					end
					OP_DIV: begin
						sgn_q <= a[31] ^ b[31];
						if (a[30:23] == '0) begin
							res_q <= {a[31] ^ b[31], 31'd0};
							done_q <= 1'b1;
						end else if (b[30:23] == '0) begin
							res_q <= {a[31] ^ b[31], 31'd0} | FP_INF;
							done_q <= 1'b1;
						end else begin
							busy_q <= 1'b1;
							cnt_q  <= 5'(QUO_BITS);
							den_q  <= mq;
							quo_q  <= '0;
							rem_q  <= (mp < mq) ? {1'b0, mp, 1'b0} : {2'b0, mp};
							exp_q  <= (mp < mq) ? e0 - 11'sd1 : e0;
						end
					end
					default: ;
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= div_res;
				end else begin
					cnt_q <= cnt_q - 5'd1;
					if (rem_q >= {2'b0, den_q}) begin
						rem_q <= diffr << 1;
						quo_q <= {quo_q[23:0], 1'b1};
					end else begin
						rem_q <= rem_q << 1;
						quo_q <= {quo_q[23:0], 1'b0};
					end
				end
			end
		end
	end
endmodule

[hdl/fp32_newton_square_root_top.sv]
// Top level of the fp32 Newton square root block.
// Depends on fnsr_pkg, fnsr_conv and fnsr_unit.
//
//  channel  | handshake           | payload
//  in       | in_valid/in_stall   | radicand[31:0]
//  out      | out_valid/out_stall | root_bits[31:0]
//  cfg      | cfg_valid/cfg_ready | cfg_data[3:0] (iteration_count)
//
// No new input is taken until the sequencer is idle again. An item is
// converted, then runs N steps, N the iteration count: each step runs two
// bit-serial divisions (start, 25 quotient bits, round, handoff) and an add.
// Reset clears the sequencer and output valid flag and sets the count to 5.
// A result waits in an output register; a stall holds it, and the next
// input is taken meanwhile. DONE waits while the register is full and stalled.
module fp32_newton_square_root_top import fnsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] radicand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] root_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	state_t state_q, state_d;
	logic [3:0]  iter_q, left_q;
	logic [31:0] value_q, guess_q, init_q, x_q;
	logic        zero_q;
	unit_ctl_t   ctl;
	unit_sts_t   sts;
	logic [31:0] ua, ub, ures;
	logic        fired_q;
	logic        accept;
	logic        load_out;
	logic        out_valid_q;
	logic [31:0] root_q;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	fnsr_conv u_conv (
		.clk(clk), .load(accept), .radicand(radicand),
		.value_q(value_q), .guess_q(init_q)
	);

	fnsr_unit u_unit (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(ua), .b(ub),
		.sts(sts), .res_q(ures)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_CONV;
			ST_CONV: state_d = (zero_q || iter_q == '0) ? ST_DONE : ST_DIVQ;
			ST_DIVQ: if (sts.done) state_d = ST_ADD;
			ST_ADD:  if (sts.done) state_d = ST_DIVH;
			ST_DIVH: if (sts.done) state_d = (left_q == 4'd1) ? ST_DONE : ST_DIVQ;
			ST_DONE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.start = 1'b0;
		ctl.op = OP_DIV;
		ua = x_q; ub = guess_q;
		unique case (state_q)
			ST_DIVQ: begin ctl.start = !fired_q; ctl.op = OP_DIV; end
			ST_ADD:  begin ctl.start = !fired_q; ctl.op = OP_ADD; ub = ures; ua = guess_q; end
			ST_DIVH: begin ctl.start = !fired_q; ctl.op = OP_DIV; ua = ures; ub = FP_TWO; end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign root_bits = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= ITER_RESET;
			fired_q     <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) iter_q <= cfg_data;
			if (sts.done || state_d != state_q) fired_q <= 1'b0;
			else if (ctl.start) fired_q <= 1'b1;
			if (state_q == ST_CONV) left_q <= iter_q;
			else if (state_q == ST_DIVH && sts.done) left_q <= left_q - 4'd1;
			// refill the word slot, or drop the word once taken
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) zero_q <= (radicand == '0);
		if (state_q == ST_CONV) begin
			guess_q <= init_q;
			x_q <= value_q;
		end
		if (state_q == ST_DIVH && sts.done) guess_q <= ures;
		if (load_out) root_q <= zero_q ? '0 : guess_q;
	end
endmodule

[hdl/fnsr_checker.sv]
// Port-level checks for the fp32 Newton square root block.
// Depends only on the top level's ports; bound below.
module fnsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] root_bits
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(root_bits))
		else $error("result word changed under stall");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall [*2])
		else $error("input taken again before conversion ended");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(root_bits))
		else $error("result word unknown");
	a_ctl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown");
endmodule

bind fp32_newton_square_root_top fnsr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .root_bits(root_bits)
);

[test/tb_fp32_newton_square_root_top.sv]
// Testbench for fp32_newton_square_root_top: drives radicands, predicts each fp32 root
// in integer-only arithmetic and checks the output words in order.
// Depends on fnsr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_fp32_newton_square_root_top;
	import fnsr_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int DRAIN_CYCLES = 1000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] radicand;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] root_bits;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;

	logic [31:0] expected_roots[$];
	logic [3:0]  steps_cfg;
	int          mismatch_count;
	int          cycle_count;
	int          sent_count;
	int          checked_count;
	int          cfg_writes;
	bit          idle_enable;
	int          hold_cycles;
	int          rx_burst;

	fp32_newton_square_root_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.radicand  (radicand),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root_bits (root_bits),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------- fp32 predictor ----------------
	function automatic int lead_zero_count(logic [31:0] v);
		int n;
		n = 0;
		if (v == 0)
			return 32;
		while (!v[31]) begin
			v = v << 1;
			n++;
		end
		return n;
	endfunction

	function automatic logic [31:0] uint_to_fp32(logic [31:0] v);
		int          e;
		logic [31:0] m;
		if (v == 0)
			return 32'd0;
		e = 31 - lead_zero_count(v);
		if (e <= 23)
			m = v << (23 - e);
		else
			m = v >> (e - 23);
		return (32'(e + FP_BIAS) << 23) | (m & FP_FRAC);
	endfunction

	function automatic logic [31:0] fp32_sum(logic [31:0] a, logic [31:0] b);
		logic [31:0] sa, sb, aa, ab, tmp, ma, mb, m;
		int          ea, eb, diff, e;
		if (a[30:0] == 0)
			return b;
		if (b[30:0] == 0)
			return a;
		sa = a & FP_SIGN;
		sb = b & FP_SIGN;
		aa = {1'b0, a[30:0]};
		ab = {1'b0, b[30:0]};
		if (aa < ab) begin
			tmp = aa; aa = ab; ab = tmp;
			tmp = sa; sa = sb; sb = tmp;
		end
		ea = int'(aa[30:23]);
		eb = int'(ab[30:23]);
		ma = (ea != 0) ? ((aa & FP_FRAC) | FP_HIDDEN) : (aa & FP_FRAC);
		mb = (eb != 0) ? ((ab & FP_FRAC) | FP_HIDDEN) : (ab & FP_FRAC);
		diff = ea - eb;
		mb = (diff < 32) ? (mb >> diff) : 32'd0;
		m = (sa != sb) ? (ma - mb) : (ma + mb);
		if (m == 0)
			return 32'd0;
		e = ea;
		if (m[24]) begin
			m = m >> 1;
			e++;
		end else begin
			while (!m[23]) begin
				m = m << 1;
				e--;
			end
		end
		if (e <= 0)
			return 32'd0;
		if (e >= 255)
			return sa | FP_INF;
		return sa | (32'(e) << 23) | (m & FP_FRAC);
	endfunction

	function automatic logic [31:0] fp32_quotient(logic [31:0] p, logic [31:0] q);
		logic [31:0] sign, mp, mq, quo;
		int          e;
		bit          up;
		sign = (p ^ q) & FP_SIGN;
		quo = 32'd0;
		if (p[30:23] == 0)
			return sign;
		if (q[30:23] == 0)
			return sign | FP_INF;
		mp = (p & FP_FRAC) | FP_HIDDEN;
		mq = (q & FP_FRAC) | FP_HIDDEN;
		e = int'(p[30:23]) - int'(q[30:23]) + FP_BIAS;
		if (mp < mq) begin
			mp = mp << 1;
			e--;
		end
		for (int i = 0; i < QUO_BITS; i++) begin
			quo = quo << 1;
			if (mp >= mq) begin
				mp = mp - mq;
				quo[0] = 1'b1;
			end
			mp = mp << 1;
		end
		up = quo[0] && (mp != 0 || quo[1]);
		quo = (quo >> 1) + (up ? 32'd1 : 32'd0);
		if (quo[24]) begin
			quo = quo >> 1;
			e++;
		end
		if (e <= 0)
			return sign;
		if (e >= 255)
			return sign | FP_INF;
		return sign | (32'(e) << 23) | (quo & FP_FRAC);
	endfunction

	function automatic logic [31:0] newton_root(logic [31:0] x, logic [3:0] steps);
		int          half;
		logic [31:0] guess, xf;
		if (x == 0)
			return 32'd0;
		half = (32 - lead_zero_count(x)) / 2;
		guess = uint_to_fp32(x >> half);
		if (guess == 0)
			guess = FP_TWO;
		xf = uint_to_fp32(x);
		for (int i = 0; i < steps; i++) begin
			guess = fp32_sum(guess, fp32_quotient(xf, guess));
			guess = fp32_quotient(guess, FP_TWO);
		end
		return guess;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_roots.size() == 0) begin
				report_mismatch($sformatf("unexpected word root_bits=%h", root_bits));
			end else begin
				want = expected_roots.pop_front();
				checked_count++;
				if (root_bits !== want)
					report_mismatch($sformatf("root_bits=%h want %h", root_bits, want));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words pending", cycle_count,
				expected_roots.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: long hold-off when requested, otherwise random stall bursts while idling is enabled
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (rx_burst > 0) begin
			rx_burst <= rx_burst - 1;
			out_stall <= 1'b1;
		end else if (idle_enable && $urandom_range(0, 7) == 0) begin
			rx_burst <= $urandom_range(1, 19) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------- stimulus ----------------
	task automatic send_radicand(logic [31:0] v);
		int gap;
		gap = (idle_enable && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		radicand <= v;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		expected_roots.push_back(newton_root(v, steps_cfg));
		sent_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_iterations(logic [3:0] n);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		steps_cfg = n;
		cfg_writes++;
	endtask

	function automatic logic [31:0] pick_radicand();
		logic [31:0] k;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 255);
			2: begin
				k = 32'd1 << $urandom_range(0, 31);
				return k + 32'($urandom_range(0, 2)) - 32'd1;
			end
			3: return $urandom >> $urandom_range(0, 31);
			4: begin
				k = $urandom_range(0, 65535);
				return k * k;
			end
			default: return 32'h0100_0000 + 32'($urandom_range(0, 64)) - 32'd32;
		endcase
	endfunction

	task automatic test_directed_values();
		logic [31:0] vals[$];
		vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd144, 32'h00FF_FFFF, 32'h0100_0000,
			32'h0100_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_0001, 32'hFFFF_FFFF,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0400};
		foreach (vals[i])
			send_radicand(vals[i]);
	endtask

	task automatic test_iteration_extremes();
		logic [3:0]  counts[3];
		logic [31:0] vals[6];
		counts = '{4'd0, 4'd15, 4'd1};
		vals = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h0100_0001, 32'h1234_5678};
		foreach (counts[c]) begin
			write_iterations(counts[c]);
			foreach (vals[i])
				send_radicand(vals[i]);
		end
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 10; ph++) begin
			write_iterations(4'($urandom_range(1, 7)));
			repeat (150)
				send_radicand(pick_radicand());
		end
	endtask

	task automatic test_backpressure();
		write_iterations(4'd2);
		hold_cycles = 3000;
		repeat (30)
			send_radicand(pick_radicand());
		wait_drained();
		repeat (10)
			send_radicand(pick_radicand());
	endtask

	task automatic test_no_idle();
		write_iterations(4'd3);
		idle_enable = 1'b0;
		repeat (150)
			send_radicand(pick_radicand());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		radicand = 32'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 4'd0;
		steps_cfg = ITER_RESET;
		mismatch_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		cfg_writes = 0;
		idle_enable = 1'b1;
		hold_cycles = 0;
		rx_burst = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_values();
		test_iteration_extremes();
		test_random_phases();
		test_backpressure();
		test_no_idle();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_roots.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", expected_roots.size()));
		$display("Sent %0d radicands, checked %0d roots over %0d iteration-count settings",
			sent_count, checked_count, cfg_writes);
		$display("Covered zero/one/max inputs, the 2^24 truncation edge, long stalls, no idling");
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
